// ===== rtl/sgtr_pkg.sv =====
// sgtr_pkg: shared constants, types and font functions of the glyph text renderer
// no dependencies; used by the channel interfaces and every rtl module
package sgtr_pkg;

  localparam int MAX_GLYPHS_DEF = 64;
  localparam int MAX_SCALE_DEF  = 8;

  localparam int CW    = 5;
  localparam int CH    = 7;
  localparam int GAP   = 1;
  localparam int PITCH = CW + GAP;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int PX_W      = 12;
  localparam int PY_W      = 6;
  localparam int COLOR_W   = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int SCALE_W   = 4;
  localparam int IW_W      = 12;
  localparam int IH_W      = 6;
  localparam int GLYPH_W   = 4;
  localparam int ROW_W     = 3;
  localparam int COL_IDX_W = 3;

  localparam logic [COLOR_W-1:0] ALPHA_ON = 8'hFF;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FORE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

  localparam logic [CFG_W-1:0]   FORE_RESET  = 24'hFFFFFF;
  localparam logic [CFG_W-1:0]   BACK_RESET  = 24'h000000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;

  localparam logic [CHAR_W-1:0]  DIGIT_FIRST = 8'h30;
  localparam logic [CHAR_W-1:0]  DIGIT_LAST  = 8'h39;
  localparam logic [CHAR_W-1:0]  CROSS_CHAR  = 8'h78;
  localparam logic [GLYPH_W-1:0] CROSS_CODE  = 4'd10;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  typedef struct packed {
    logic [PX_W-1:0] gx;
    logic [PY_W-1:0] gy;
    logic [PX_W-1:0] idx;
  } coord_t;

  // valid flag on top, font index below
  function automatic logic [GLYPH_W:0] char_lookup(input logic [CHAR_W-1:0] c);
    logic [GLYPH_W:0] res;
    res = '0;
    if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
      res = {1'b1, GLYPH_W'(c - DIGIT_FIRST)};
    end else if (c == CROSS_CHAR) begin
      res = {1'b1, CROSS_CODE};
    end
    return res;
  endfunction

  // one font row, bit 4 is the leftmost column
  function automatic logic [CW-1:0] font_row(input logic [GLYPH_W-1:0] code,
                                             input logic [ROW_W-1:0] row);
    logic [CH*CW-1:0] bits;
    logic [ROW_W-1:0] ri;
    ri = ROW_W'(CH - 1) - row;
    case (code)
      4'd0:    bits = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      4'd1:    bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      4'd2:    bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      4'd3:    bits = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      4'd4:    bits = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      4'd5:    bits = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      4'd6:    bits = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      4'd7:    bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      4'd8:    bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      4'd9:    bits = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      4'd10:   bits = {5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h00};
      default: bits = '0;
    endcase
    return (row < ROW_W'(CH)) ? bits[ri*CW +: CW] : '0;
  endfunction

endpackage

// ===== rtl/sgtr_if.sv =====
// sgtr_in_if / sgtr_out_if: valid-ready channels carrying command and result items
// depends on sgtr_pkg for field widths
interface sgtr_in_if;
  import sgtr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [PX_W-1:0]   pixel_x;
  logic [PY_W-1:0]   pixel_y;

  modport source (output valid, cmd, char_code, pixel_x, pixel_y, input ready);
  modport sink (input valid, cmd, char_code, pixel_x, pixel_y, output ready);
endinterface

interface sgtr_out_if;
  import sgtr_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] alpha;
  logic               inside_res;
  logic               accepted;
  logic [IW_W-1:0]    image_width;
  logic [IH_W-1:0]    image_height;

  modport source (output valid, red, green, blue, alpha, inside_res, accepted,
                  image_width, image_height, input ready);
  modport sink (input valid, red, green, blue, alpha, inside_res, accepted,
                image_width, image_height, output ready);
endinterface

// ===== rtl/sgtr_store.sv =====
// sgtr_store: glyph string memory, one write and one registered read port
// depends on sgtr_pkg
module sgtr_store #(
  parameter int MAX_GLYPHS = sgtr_pkg::MAX_GLYPHS_DEF,
  localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [sgtr_pkg::GLYPH_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [sgtr_pkg::GLYPH_W-1:0] rdata
);
  import sgtr_pkg::*;

  logic [GLYPH_W-1:0] mem_r [MAX_GLYPHS];
  logic [GLYPH_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sgtr_coord.sv =====
// sgtr_coord: maps a pixel coordinate to glyph index and unscaled position
// divides by scale and by glyph pitch times scale with reciprocal tables; depends on sgtr_pkg
module sgtr_coord #(
  parameter int MAX_SCALE = sgtr_pkg::MAX_SCALE_DEF,
  localparam int SC_W = $clog2(MAX_SCALE + 1)
) (
  input  logic [SC_W-1:0]           scale,
  input  logic [sgtr_pkg::PX_W-1:0] pixel_x,
  input  logic [sgtr_pkg::PY_W-1:0] pixel_y,
  output sgtr_pkg::coord_t          coord
);
  import sgtr_pkg::*;

  localparam int KS   = PX_W + $clog2(MAX_SCALE);
  localparam int KP   = PX_W + $clog2(PITCH * MAX_SCALE);
  localparam int RS_W = KS + 1;
  localparam int RP_W = KP + 1;
  localparam int XS_W = PX_W + RS_W;
  localparam int YS_W = PY_W + RS_W;
  localparam int XP_W = PX_W + RP_W;

  logic [RS_W-1:0] rs_tab [1:MAX_SCALE];
  logic [RP_W-1:0] rp_tab [1:MAX_SCALE];
  logic [RS_W-1:0] rs;
  logic [RP_W-1:0] rp;
  logic [XS_W-1:0] x_prod;
  logic [YS_W-1:0] y_prod;
  logic [XP_W-1:0] i_prod;

  // rounded-up reciprocals, exact for every coordinate in range
  for (genvar i = 1; i <= MAX_SCALE; i++) begin : g_recip
    localparam longint RS = ((longint'(1) << KS) + i - 1) / i;
    localparam longint RP = ((longint'(1) << KP) + PITCH * i - 1) / (PITCH * i);
    assign rs_tab[i] = RS_W'(RS);
    assign rp_tab[i] = RP_W'(RP);
  end

  assign rs     = rs_tab[scale];
  assign rp     = rp_tab[scale];
  assign x_prod = XS_W'(pixel_x) * XS_W'(rs);
  assign y_prod = YS_W'(pixel_y) * YS_W'(rs);
  assign i_prod = XP_W'(pixel_x) * XP_W'(rp);

  assign coord.gx  = PX_W'(x_prod >> KS);
  assign coord.gy  = PY_W'(y_prod >> KS);
  assign coord.idx = PX_W'(i_prod >> KP);

endmodule

// ===== rtl/scaled_glyph_text_renderer_unit.sv =====
// scaled_glyph_text_renderer_unit: text overlay generator with a 5x7 digit font
// depends on sgtr_pkg, sgtr_if, sgtr_store and sgtr_coord
//
// in_if carries command items: clear the string, append a character, read a pixel.
// out_if returns one result item per command: pixel colour, alpha, inside flag,
// accepted flag and the image width and height after the command.
// cfg_we/cfg_index/cfg_data write foreground colour, background colour and scale;
// writes are taken at any edge; the user must write only between items, as the block does not enforce it.
// An accepted item has its fields registered and its glyph memory read done at
// the accept edge, then its result is loaded into the output register; the unit
// takes no new item until then. The coordinate divides run in the accept cycle.
// in_if.ready is high while no item is in flight, even when a result is still
// waiting on out_if. A stalled receiver holds the result; the next item then
// waits in the execute state until the output register frees up.
// Reset empties the string and loads the register defaults. The glyph memory
// is not cleared; only entries below the glyph count ever affect a result.
module scaled_glyph_text_renderer_unit #(
  parameter int MAX_GLYPHS = sgtr_pkg::MAX_GLYPHS_DEF,
  parameter int MAX_SCALE  = sgtr_pkg::MAX_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sgtr_in_if.sink                       in_if,
  sgtr_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [sgtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgtr_pkg::CFG_W-1:0]    cfg_data
);
  import sgtr_pkg::*;

  localparam int AW    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int CNT_W = $clog2(MAX_GLYPHS + 1);
  localparam int SC_W  = $clog2(MAX_SCALE + 1);
  localparam int NM_W  = $clog2(PITCH * MAX_GLYPHS + 1);
  localparam int W_W   = $clog2(PITCH * MAX_GLYPHS * MAX_SCALE + 1);
  localparam int WC_W  = (W_W > PX_W) ? W_W : PX_W;
  localparam int H_W   = $clog2(CH * MAX_SCALE + 1);
  localparam int HC_W  = (H_W > PY_W) ? H_W : PY_W;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   fore_r, back_r;
  logic [SCALE_W-1:0] scale_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SC_W-1:0]    scale_eff;

  logic [NM_W-1:0]    cols_m1;
  logic [WC_W-1:0]    img_w;
  logic [HC_W-1:0]    img_h;
  logic               inside_now;

  logic               in_fire, in_ready, out_load;
  logic [GLYPH_W:0]   lk;
  logic               can_store;
  logic               acc_now;
  coord_t             coord;
  logic [GLYPH_W-1:0] glyph_rd;

  logic [CMD_W-1:0]   cmd_r;
  logic               acc_r, inside_r;
  logic [PX_W-1:0]    gx_r, idx_r;
  logic [PY_W-1:0]    gy_r;

  logic [COL_IDX_W-1:0] col;
  logic [CW-1:0]        row_bits;
  logic                 pix_on;
  logic [CFG_W-1:0]     colour;

  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic               inside_res_r, accepted_r;
  logic [IW_W-1:0]    iw_r;
  logic [IH_W-1:0]    ih_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r  <= FORE_RESET;
      back_r  <= BACK_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORE:  fore_r  <= cfg_data;
        CFG_BACK:  back_r  <= cfg_data;
        CFG_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_r == '0) begin
      scale_eff = SC_W'(1);
    end else if ({1'b0, scale_r} > (SCALE_W + 1)'(MAX_SCALE)) begin
      scale_eff = SC_W'(MAX_SCALE);
    end else begin
      scale_eff = SC_W'(scale_r);
    end
  end

  // image size from the current glyph count
  assign cols_m1 = NM_W'(count_r) * NM_W'(PITCH) - NM_W'(1);
  assign img_w   = (count_r == '0) ? '0 : WC_W'(cols_m1) * WC_W'(scale_eff);
  assign img_h   = (count_r == '0) ? '0 : HC_W'(CH) * HC_W'(scale_eff);
  assign inside_now = (WC_W'(in_if.pixel_x) < img_w) && (HC_W'(in_if.pixel_y) < img_h);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_if.ready = in_ready;
  assign in_fire     = in_if.valid && in_ready;

  assign lk        = char_lookup(in_if.char_code);
  assign can_store = lk[GLYPH_W] && (count_r < CNT_W'(MAX_GLYPHS));

  always_comb begin
    count_nxt = count_r;
    acc_now   = 1'b0;
    case (in_if.cmd)
      CMD_CLEAR: begin
        acc_now = 1'b1;
        if (in_fire) begin
          count_nxt = '0;
        end
      end
      CMD_APPEND: begin
        acc_now = can_store;
        if (in_fire && can_store) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_READ: acc_now = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  sgtr_coord #(
    .MAX_SCALE (MAX_SCALE)
  ) u_coord (
    .scale   (scale_eff),
    .pixel_x (in_if.pixel_x),
    .pixel_y (in_if.pixel_y),
    .coord   (coord)
  );

  sgtr_store #(
    .MAX_GLYPHS (MAX_GLYPHS)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && in_if.cmd == CMD_APPEND && can_store),
    .waddr (count_r[AW-1:0]),
    .wdata (lk[GLYPH_W-1:0]),
    .re    (in_fire && in_if.cmd == CMD_READ),
    .raddr (coord.idx[AW-1:0]),
    .rdata (glyph_rd)
  );

  // item registers for the execute state
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_if.cmd;
      acc_r    <= acc_now;
      inside_r <= (in_if.cmd == CMD_READ) && inside_now;
      gx_r     <= coord.gx;
      gy_r     <= coord.gy;
      idx_r    <= coord.idx;
    end
  end

  // column inside the glyph pitch, the gap column is the last one
  assign col      = COL_IDX_W'(gx_r - ((idx_r << 2) + (idx_r << 1)));
  assign row_bits = font_row(glyph_rd, gy_r[ROW_W-1:0]);
  assign pix_on   = inside_r && (col < COL_IDX_W'(CW)) && (idx_r < PX_W'(count_r))
                    && (gy_r < PY_W'(CH)) && row_bits[COL_IDX_W'(CW - 1) - col];
  assign colour   = !inside_r ? '0 : (pix_on ? fore_r : back_r);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_r        <= colour[COLOR_W-1:0];
      green_r      <= colour[2*COLOR_W-1:COLOR_W];
      blue_r       <= colour[3*COLOR_W-1:2*COLOR_W];
      alpha_r      <= inside_r ? ALPHA_ON : '0;
      inside_res_r <= inside_r && (cmd_r == CMD_READ);
      accepted_r   <= acc_r;
      iw_r         <= img_w[IW_W-1:0];
      ih_r         <= img_h[IH_W-1:0];
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.red          = red_r;
  assign out_if.green        = green_r;
  assign out_if.blue         = blue_r;
  assign out_if.alpha        = alpha_r;
  assign out_if.inside_res   = inside_res_r;
  assign out_if.accepted     = accepted_r;
  assign out_if.image_width  = iw_r;
  assign out_if.image_height = ih_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_GLYPHS))
    else $error("glyph count above store depth");

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted item not in flight");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && !out_if.ready) |=> (state_r == ST_EXEC))
    else $error("item left execute while output stalled");

  a_inside_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.inside_res) |-> (out_if.alpha == ALPHA_ON && out_if.accepted))
    else $error("inside pixel without full alpha or accept");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for scaled_glyph_text_renderer_unit
// needs sgtr_pkg, sgtr_in_if/sgtr_out_if and the unit; register writes between phases
// a scoreboard class predicts every result item and checks it against the out channel
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sgtr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int               NGLYPH     = MAX_GLYPHS_DEF;
  localparam int               NSCALE     = MAX_SCALE_DEF;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        in_img;
    logic        acc;
    logic [11:0] width;
    logic [5:0]  height;
  } pixel_res_t;

  class render_scoreboard;
    logic [23:0] fore;
    logic [23:0] back;
    logic [3:0]  scale;
    logic [3:0]  glyphs[NGLYPH];
    int unsigned count;
    pixel_res_t  want_q[$];
    int          errors;
    int          n_checked;

    function void reset_state();
      fore = FORE_RESET;
      back = BACK_RESET;
      scale = SCALE_RESET;
      count = 0;
      errors = 0;
      n_checked = 0;
      want_q.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] data);
      case (idx)
        CFG_FORE: fore = data;
        CFG_BACK: back = data;
        CFG_SCALE: scale = data[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_scale();
      int unsigned s;
      s = scale;
      if (s < 1) s = 1;
      if (s > NSCALE) s = NSCALE;
      return s;
    endfunction

    function int unsigned width_now();
      if (count == 0) return 0;
      return (count * 6 - 1) * eff_scale();
    endfunction

    function int unsigned height_now();
      if (count == 0) return 0;
      return 7 * eff_scale();
    endfunction

    function int glyph_index(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c == 8'h78) return 10;
      return -1;
    endfunction

    // seven rows of five bits, top row in the high bits, bit 4 leftmost
    function logic [34:0] glyph_bits(int code);
      case (code)
        0: return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
        1: return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
        2: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
        3: return {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
        4: return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
        5: return {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
        6: return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
        7: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
        8: return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
        9: return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
        10: return {5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h00};
        default: return '0;
      endcase
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] ch, logic [11:0] px,
                             logic [5:0] py);
      pixel_res_t  r;
      int          code;
      int unsigned w, h, s, gx, gy, gidx, col;
      logic [34:0] bits;
      logic        lit;
      logic [23:0] colour;
      r = '0;
      colour = '0;
      case (cmd)
        CMD_CLEAR: begin
          count = 0;
          r.acc = 1'b1;
        end
        CMD_APPEND: begin
          code = glyph_index(ch);
          if (code >= 0 && count < NGLYPH) begin
            glyphs[count] = code[3:0];
            count++;
            r.acc = 1'b1;
          end
        end
        CMD_READ: begin
          w = width_now();
          h = height_now();
          r.acc = 1'b1;
          if (px < w && py < h) begin
            s = eff_scale();
            gx = px / s;
            gy = py / s;
            gidx = gx / 6;
            col = gx % 6;
            lit = 1'b0;
            r.in_img = 1'b1;
            r.alpha = 8'hFF;
            if (col < 5 && gidx < count && gy < 7) begin
              bits = glyph_bits(int'(glyphs[gidx]));
              lit = bits[(6 - gy) * 5 + (4 - col)];
            end
            colour = lit ? fore : back;
          end
        end
        default: ;
      endcase
      r.red = colour[7:0];
      r.green = colour[15:8];
      r.blue = colour[23:16];
      r.width = 12'(width_now());
      r.height = 6'(height_now());
      want_q.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch: result %0d %s got %0d want %0d", n_checked, what, got, want);
      errors++;
    endtask

    task check_result(pixel_res_t got);
      pixel_res_t want;
      if (want_q.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        want = want_q.pop_front();
        if (got.red !== want.red) report("red", got.red, want.red);
        if (got.green !== want.green) report("green", got.green, want.green);
        if (got.blue !== want.blue) report("blue", got.blue, want.blue);
        if (got.alpha !== want.alpha) report("alpha", got.alpha, want.alpha);
        if (got.in_img !== want.in_img) report("inside_res", got.in_img, want.in_img);
        if (got.acc !== want.acc) report("accepted", got.acc, want.acc);
        if (got.width !== want.width) report("image_width", got.width, want.width);
        if (got.height !== want.height) report("image_height", got.height, want.height);
      end
      n_checked++;
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sgtr_in_if  in_ch();
  sgtr_out_if out_ch();

  scaled_glyph_text_renderer_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  render_scoreboard sb;
  bit idle_on;
  bit rx_hold;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                       out_ch.inside_res, out_ch.accepted, out_ch.image_width,
                       out_ch.image_height});
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task send_item(logic [1:0] cmd, logic [7:0] ch, logic [11:0] px, logic [5:0] py);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.char_code <= ch;
    in_ch.pixel_x <= px;
    in_ch.pixel_y <= py;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(cmd, ch, px, py);
    items_sent++;
    @(negedge clk);
  endtask

  task wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  function automatic logic [23:0] pick_colour();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_scale();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd8;
      2: return 4'd9;
      3: return 4'd15;
      4, 5, 6: return 4'd1;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [7:0] pick_glyph_char();
    int k;
    k = $urandom_range(0, 10);
    return (k == 10) ? 8'h78 : 8'(8'h30 + k);
  endfunction

  task read_random_pixel();
    int unsigned w, h;
    w = sb.width_now();
    h = sb.height_now();
    if (w != 0 && $urandom_range(0, 4) != 0) begin
      send_item(CMD_READ, 8'($urandom), 12'($urandom_range(0, w - 1)),
                6'($urandom_range(0, h - 1)));
    end else begin
      send_item(CMD_READ, 8'($urandom), 12'($urandom), 6'($urandom));
    end
  endtask

  initial begin
    int n_app, n_rd, k, phase;
    int unsigned w, h;
    sb = new();
    sb.reset_state();
    idle_on = 1'b1;
    rx_hold = 1'b0;
    items_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FORE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.char_code = '0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty string, unused command, rejected bytes, full font, edges
    send_item(CMD_READ, 8'h00, 12'd0, 6'd0);
    send_item(CMD_UNUSED, 8'hFF, 12'hFFF, 6'h3F);
    send_item(CMD_APPEND, 8'h2F, 12'd0, 6'd0);
    send_item(CMD_APPEND, 8'h3A, 12'd0, 6'd0);
    send_item(CMD_APPEND, 8'h77, 12'd0, 6'd0);
    for (k = 0; k < 10; k++) send_item(CMD_APPEND, 8'(8'h30 + k), 12'd0, 6'd0);
    send_item(CMD_APPEND, 8'h78, 12'd0, 6'd0);
    w = sb.width_now();
    h = sb.height_now();
    send_item(CMD_READ, 8'h00, 12'd0, 6'd0);
    send_item(CMD_READ, 8'h00, 12'd5, 6'd1);
    send_item(CMD_READ, 8'h00, 12'(w - 1), 6'(h - 1));
    send_item(CMD_READ, 8'h00, 12'(w), 6'd0);
    send_item(CMD_READ, 8'h00, 12'd0, 6'(h));
    send_item(CMD_READ, 8'h00, 12'hFFF, 6'h3F);
    send_item(CMD_CLEAR, 8'h00, 12'd0, 6'd0);
    send_item(CMD_READ, 8'h00, 12'd0, 6'd0);

    phase = 0;
    while (items_sent < 2000) begin
      wait_idle();
      if (items_sent > 1700) idle_on = 1'b0;
      if (phase == 0 || $urandom_range(0, 2) != 0) cfg_write(CFG_FORE, pick_colour());
      if (phase == 0 || $urandom_range(0, 2) != 0) cfg_write(CFG_BACK, pick_colour());
      if (phase == 0 || $urandom_range(0, 1) != 0) begin
        cfg_write(CFG_SCALE, {20'($urandom), pick_scale()});
      end
      cfg_we <= 1'b0;
      @(negedge clk);
      if (phase == 6) rx_hold = 1'b1;

      if ($urandom_range(0, 5) != 0) send_item(CMD_CLEAR, 8'($urandom), 12'($urandom),
                                               6'($urandom));
      n_app = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 72) : $urandom_range(1, 8);
      for (k = 0; k < n_app; k++) begin
        case ($urandom_range(0, 19))
          0, 1: send_item(CMD_APPEND, 8'($urandom), 12'($urandom), 6'($urandom));
          2: send_item(CMD_UNUSED, 8'($urandom), 12'($urandom), 6'($urandom));
          3: read_random_pixel();
          default: send_item(CMD_APPEND, pick_glyph_char(), 12'($urandom), 6'($urandom));
        endcase
      end
      n_rd = $urandom_range(10, 40);
      for (k = 0; k < n_rd; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          send_item(CMD_UNUSED, 8'($urandom), 12'($urandom), 6'($urandom));
        end else begin
          read_random_pixel();
        end
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    for (k = 0; k < 2000 && sb.want_q.size() != 0; k++) @(posedge clk);
    if (sb.want_q.size() != 0) sb.report("missing items", sb.want_q.size(), 0);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
